// ===== sv/sta_pkg.sv =====
// Shared types and constants for the slot table allocator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package sta_pkg;

   localparam int SLOTS       = 64;
   localparam int HANDLE_BITS = 32;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int CNT_W       = $clog2(SLOTS + 1);

   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(SLOTS);

   typedef enum logic [1:0] {
      MODE_PUT           = 2'd0,
      MODE_REMOVE_INDEX  = 2'd1,
      MODE_REMOVE_HANDLE = 2'd2,
      MODE_RESERVED      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD       = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      mode_type          mode;
      logic [31:0]       handle;
      logic [IDX_W-1:0]  slot_index;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  slot;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  first_free;
      logic [CNT_W-1:0]  used_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HOLE_SCAN,
      ST_FIND_ISSUE,
      ST_FIND_CHECK,
      ST_SHRINK,
      ST_REPLY
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_REJECT,
      OP_PUT,
      OP_HOLE_STEP,
      OP_CLEAR_INDEX,
      OP_CLEAR_SCAN,
      OP_FIND_INIT,
      OP_FIND_READ,
      OP_SCAN_NEXT,
      OP_SHRINK_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      status_type  status;
   } dp_cmd_type;

   typedef struct packed {
      mode_type  mode;
      logic      handle_null;
      logic      full;
      logic      put_scan;
      logic      index_ok;
      logic      index_tops;
      logic      scan_in_range;
      logic      scan_free;
      logic      match;
      logic      scan_tops;
      logic      can_shrink;
   } dp_flags_type;

endpackage

// ===== sv/sta_ctrl.sv =====
// Controller state machine of the slot table allocator.
// Issues datapath commands and reads its flags; depends on sta_pkg.
module sta_ctrl
   import sta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_flags_type  flags,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          reply
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.status = STATUS_BAD;
      busy       = (state_ff != ST_IDLE);
      reply      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (flags.mode)
               MODE_PUT: begin
                  if (flags.handle_null) begin
                     cmd.op   = OP_REJECT;
                     state_in = ST_REPLY;
                  end else if (flags.full) begin
                     cmd.op     = OP_REJECT;
                     cmd.status = STATUS_FULL;
                     state_in   = ST_REPLY;
                  end else begin
                     cmd.op   = OP_PUT;
                     state_in = flags.put_scan ? ST_HOLE_SCAN : ST_REPLY;
                  end
               end
               MODE_REMOVE_INDEX: begin
                  if (flags.index_ok) begin
                     cmd.op   = OP_CLEAR_INDEX;
                     state_in = flags.index_tops ? ST_SHRINK : ST_REPLY;
                  end else begin
                     cmd.op   = OP_REJECT;
                     state_in = ST_REPLY;
                  end
               end
               MODE_REMOVE_HANDLE: begin
                  if (flags.handle_null) begin
                     cmd.op   = OP_REJECT;
                     state_in = ST_REPLY;
                  end else begin
                     cmd.op   = OP_FIND_INIT;
                     state_in = ST_FIND_ISSUE;
                  end
               end
               default: begin
                  cmd.op   = OP_REJECT;
                  state_in = ST_REPLY;
               end
            endcase
         end
         ST_HOLE_SCAN: begin
            cmd.op = OP_HOLE_STEP;
            if (!flags.scan_in_range || flags.scan_free) begin
               state_in = ST_REPLY;
            end
         end
         ST_FIND_ISSUE: begin
            if (flags.scan_in_range) begin
               cmd.op   = OP_FIND_READ;
               state_in = ST_FIND_CHECK;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_FIND_CHECK: begin
            if (flags.match) begin
               cmd.op   = OP_CLEAR_SCAN;
               state_in = flags.scan_tops ? ST_SHRINK : ST_REPLY;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = ST_FIND_ISSUE;
            end
         end
         ST_SHRINK: begin
            if (flags.can_shrink) begin
               cmd.op = OP_SHRINK_STEP;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            reply    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/sta_dp.sv =====
// Datapath of the slot table allocator: handle memory, occupancy bits,
// first-empty, used-end and free-count registers. Depends on sta_pkg.
module sta_dp
   import sta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req,
   input  dp_cmd_type    cmd,
   output dp_flags_type  flags,
   output rsp_type       rsp
);

   logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
   logic [HANDLE_BITS-1:0] rdata_ff;

   logic [SLOTS-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  empties_ff, empties_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   req_type           req_ff, req_in;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;

   logic [HANDLE_BITS-1:0] key;
   logic [IDX_W-1:0]       put_at;
   logic [IDX_W-1:0]       clr_at;
   logic [CNT_W-1:0]       clr_wide;
   logic [CNT_W-1:0]       end_less;

   assign key      = req_ff.handle[HANDLE_BITS-1:0];
   assign put_at   = first_ff[IDX_W-1:0];
   assign clr_at   = (cmd.op == OP_CLEAR_INDEX) ? req_ff.slot_index : scan_ff[IDX_W-1:0];
   assign clr_wide = {1'b0, clr_at};
   assign end_less = end_ff - CNT_W'(1);

   always_comb begin
      flags.mode          = req_ff.mode;
      flags.handle_null   = (key == '0);
      flags.full          = (empties_ff == '0);
      flags.put_scan      = (empties_ff != CNT_W'(1)) && (first_ff != end_ff);
      flags.index_ok      = ({1'b0, req_ff.slot_index} < end_ff)
                            && occ_ff[req_ff.slot_index];
      flags.index_tops    = ({1'b0, req_ff.slot_index} + CNT_W'(1) == end_ff);
      flags.scan_in_range = (scan_ff < end_ff);
      flags.scan_free     = !occ_ff[scan_ff[IDX_W-1:0]];
      flags.match         = occ_ff[scan_ff[IDX_W-1:0]] && (rdata_ff == key);
      flags.scan_tops     = (scan_ff + CNT_W'(1) == end_ff);
      flags.can_shrink    = (end_ff > first_ff) && !occ_ff[end_less[IDX_W-1:0]];
   end

   always_comb begin
      occ_in     = occ_ff;
      first_in   = first_ff;
      end_in     = end_ff;
      empties_in = empties_ff;
      scan_in    = scan_ff;
      req_in     = req_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      unique case (cmd.op)
         OP_LATCH: begin
            req_in    = req;
            status_in = STATUS_BAD;
            slot_in   = '0;
         end
         OP_REJECT: begin
            status_in = cmd.status;
         end
         OP_PUT: begin
            occ_in[put_at] = 1'b1;
            empties_in     = empties_ff - CNT_W'(1);
            slot_in        = put_at;
            status_in      = STATUS_OK;
            scan_in        = first_ff + CNT_W'(1);
            // The last free slot was taken: both pointers move past the table.
            if (empties_ff == CNT_W'(1)) begin
               first_in = SLOT_COUNT;
               end_in   = SLOT_COUNT;
            end else if (first_ff == end_ff) begin
               first_in = first_ff + CNT_W'(1);
               end_in   = end_ff + CNT_W'(1);
            end
         end
         OP_HOLE_STEP: begin
            if (!(scan_ff < end_ff)) begin
               first_in = end_ff;
            end else if (!occ_ff[scan_ff[IDX_W-1:0]]) begin
               first_in = scan_ff;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         OP_CLEAR_INDEX, OP_CLEAR_SCAN: begin
            occ_in[clr_at] = 1'b0;
            empties_in     = empties_ff + CNT_W'(1);
            slot_in        = clr_at;
            status_in      = STATUS_OK;
            if (clr_wide < first_ff) begin
               first_in = clr_wide;
            end
            if (clr_wide + CNT_W'(1) == end_ff) begin
               end_in = clr_wide;
            end
         end
         OP_FIND_INIT: begin
            status_in = STATUS_NOT_FOUND;
            scan_in   = '0;
         end
         OP_SCAN_NEXT: begin
            scan_in = scan_ff + CNT_W'(1);
         end
         OP_SHRINK_STEP: begin
            end_in = end_less;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         first_ff   <= '0;
         end_ff     <= '0;
         empties_ff <= SLOT_COUNT;
      end else begin
         occ_ff     <= occ_in;
         first_ff   <= first_in;
         end_ff     <= end_in;
         empties_ff <= empties_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      req_ff    <= req_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUT) begin
         handle_mem[put_at] <= key;
      end
      if (cmd.op == OP_FIND_READ) begin
         rdata_ff <= handle_mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign rsp.status     = status_ff;
   assign rsp.slot       = slot_ff;
   assign rsp.free_count = empties_ff;
   assign rsp.first_free = first_ff;
   assign rsp.used_end   = end_ff;

endmodule

// ===== sv/slot_table_allocator_core.sv =====
// Top level of the slot table allocator: joins controller and datapath.
// Depends on sta_pkg, sta_ctrl and sta_dp.
//
// Usage: drive req and raise start while busy is low; the request is
// transferred at that clock edge and busy rises in the next cycle. Exactly
// one result follows per request: rsp_strobe is high for one cycle with rsp
// valid in that same cycle, and the transfer happens at the edge ending it.
// The receiver cannot stall; it must take the result in that cycle.
// Flow per request: a put, direct or rejected, replies after the decode; a
// put that searches for the next hole passes over the occupied slots above
// the filled slot. A remove by index replies after the decode, or drops
// each trailing empty slot from the used area when the top slot was cleared.
// A remove by handle replies after the decode when rejected, else examines
// slots in turn, each through an issue and a check state, and when the top
// slot was cleared also drops each trailing empty slot.
// busy drops in the cycle after the strobe, so the next request may start
// then. The hole search and the shrink step take one slot per cycle. Reset
// empties the table at once: all slots free, first free slot and used end
// at zero; no clearing pass is needed.
module slot_table_allocator_core
   import sta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req,
   output logic     rsp_strobe,
   output rsp_type  rsp
);

   dp_cmd_type    cmd;
   dp_flags_type  flags;

   sta_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy),
      .reply (rsp_strobe)
   );

   sta_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .flags (flags),
      .rsp   (rsp)
   );

endmodule

// ===== sv/sta_checker.sv =====
// Port-level checker for the slot table allocator, bound to the top level.
// Depends on sta_pkg and slot_table_allocator_core.
module sta_checker
   import sta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  logic     rsp_strobe,
   input  rsp_type  rsp
);

   // Checks that an accepted request raises busy.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not raise busy");

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_strobe_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   a_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp.free_count <= SLOT_COUNT && rsp.first_free <= rsp.used_end
                     && rsp.used_end <= SLOT_COUNT)
      else $error("table pointers out of order");

   a_slot_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.status != STATUS_OK |-> rsp.slot == '0)
      else $error("failed request reports a nonzero slot");

endmodule

bind slot_table_allocator_core sta_checker u_sta_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);
